[design/ppp_pkg.sv]
// shared types and constants for the perspective point projection block
// no dependencies
`timescale 1ns / 1ps

package ppp_pkg;

  // configuration port geometry
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_COS_YAW        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIN_YAW        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COS_PITCH      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SIN_PITCH      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_X       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y       = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Z       = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FOCAL_DISTANCE = 3'd7;

  // fixed field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned TrigW = 16;
  localparam int unsigned FocalW = 31;

  // input word
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } ppp_in_t;

  // output word
  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic signed [CoordW-1:0] view_depth;
    logic                     depth_zero;
  } ppp_out_t;

endpackage

[design/ppp_rotate.sv]
// two stage planar rotation: a' = rnd(c*a + s*b), b' = rnd(c*b - s*a)
// depends on ppp_pkg for the trig width
`timescale 1ns / 1ps

module ppp_rotate
  import ppp_pkg::*;
#(
  parameter int unsigned IN_W = 32,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                                            clk_i,
  input  logic                                            en_i,
  input  logic signed [IN_W-1:0]                          a_i,
  input  logic signed [IN_W-1:0]                          b_i,
  input  logic signed [TrigW-1:0]                         cos_i,
  input  logic signed [TrigW-1:0]                         sin_i,
  output logic signed [IN_W+TrigW-TRIG_FRAC_BITS:0]       a_o,
  output logic signed [IN_W+TrigW-TRIG_FRAC_BITS:0]       b_o
);

  localparam int unsigned PW = IN_W + TrigW;
  localparam int unsigned SW = PW + 1;
  localparam logic [SW-1:0] Half = {{(SW-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [SW-1:0] sum_a, sum_b;
  logic [SW-1:0] rnd_a, rnd_b;

  // stage one: four products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= cos_i * a_i;
      sb_q <= sin_i * b_i;
      sa_q <= sin_i * a_i;
      cb_q <= cos_i * b_i;
    end
  end

  // sums with round half up, floor shift is the upper bits
  assign sum_a = SW'(ca_q) + SW'(sb_q);
  assign sum_b = SW'(cb_q) - SW'(sa_q);
  assign rnd_a = sum_a + Half;
  assign rnd_b = sum_b + Half;

  // stage two: rounded results
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= rnd_a[SW-1:TRIG_FRAC_BITS];
      b_o <= rnd_b[SW-1:TRIG_FRAC_BITS];
    end
  end

endmodule

[design/ppp_project.sv]
// magnitude, focal multiply, 32 step restoring divide and saturation
// depends on ppp_pkg for the output word
`timescale 1ns / 1ps

module ppp_project
  import ppp_pkg::*;
#(
  parameter int unsigned VW = 39
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [VW-1:0]  xv_i,
  input  logic signed [VW-1:0]  yv_i,
  input  logic signed [VW-1:0]  zv_i,
  input  logic [FocalW-1:0]     focal_i,
  output logic                  valid_o,
  output ppp_out_t              result_o
);

  localparam int unsigned AW = VW;
  localparam int unsigned LO = AW / 2;
  localparam int unsigned HI = AW - LO;
  localparam int unsigned PW = AW + FocalW;
  localparam int unsigned QW = CoordW;
  localparam int unsigned NDIV = QW;
  localparam int unsigned NST = 3 + NDIV + 1 + 1;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic              zero;
    logic [CoordW-1:0] depth;
  } side_t;

  logic [NST-1:0] vld_q;

  // stage a: signs, magnitudes, zero test, saturated depth
  side_t       side_a_d, side_a_q, side_b_q, side_c_q;
  logic [AW-1:0] mx_d, my_d, mz_d, mx_q, my_q, mz_q, d_b_q, d_c_q;
  logic        fits;

  assign mx_d = xv_i[VW-1] ? (~xv_i + 1'b1) : xv_i;
  assign my_d = yv_i[VW-1] ? (~yv_i + 1'b1) : yv_i;
  assign mz_d = zv_i[VW-1] ? (~zv_i + 1'b1) : zv_i;
  assign fits = (zv_i[VW-1:CoordW-1] == '0) || (zv_i[VW-1:CoordW-1] == '1);

  always_comb begin
    side_a_d.neg_x = xv_i[VW-1] ^ zv_i[VW-1];
    side_a_d.neg_y = yv_i[VW-1] ^ zv_i[VW-1];
    side_a_d.zero  = (zv_i == '0);
    if (fits) begin
      side_a_d.depth = zv_i[CoordW-1:0];
    end else if (zv_i[VW-1]) begin
      side_a_d.depth = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      side_a_d.depth = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_a_d;
      mx_q     <= mx_d;
      my_q     <= my_d;
      mz_q     <= mz_d;
    end
  end

  // stage b: split partial products with the focal distance
  logic [LO+FocalW-1:0] ppxl_q, ppyl_q;
  logic [HI+FocalW-1:0] ppxh_q, ppyh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ppxl_q   <= mx_q[LO-1:0] * focal_i;
      ppxh_q   <= mx_q[AW-1:LO] * focal_i;
      ppyl_q   <= my_q[LO-1:0] * focal_i;
      ppyh_q   <= my_q[AW-1:LO] * focal_i;
      d_b_q    <= mz_q;
      side_b_q <= side_a_q;
    end
  end

  // stage c: full products
  logic [PW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q     <= PW'(ppxl_q) + (PW'(ppxh_q) << LO);
      py_q     <= PW'(ppyl_q) + (PW'(ppyh_q) << LO);
      d_c_q    <= d_b_q;
      side_c_q <= side_b_q;
    end
  end

  // divider stage registers, entry zero holds the overflow test
  logic [AW-1:0] rx_q [NDIV+1];
  logic [AW-1:0] ry_q [NDIV+1];
  logic [QW-1:0] lx_q [NDIV+1];
  logic [QW-1:0] ly_q [NDIV+1];
  logic [QW-1:0] qx_q [NDIV+1];
  logic [QW-1:0] qy_q [NDIV+1];
  logic [AW-1:0] dd_q [NDIV+1];
  logic          ovx_q [NDIV+1];
  logic          ovy_q [NDIV+1];
  side_t         sd_q [NDIV+1];

  // stage d: quotient overflow check and initial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovx_q[0] <= AW'(px_q[PW-1:QW]) >= d_c_q;
      ovy_q[0] <= AW'(py_q[PW-1:QW]) >= d_c_q;
      rx_q[0]  <= AW'(px_q[PW-1:QW]);
      ry_q[0]  <= AW'(py_q[PW-1:QW]);
      lx_q[0]  <= px_q[QW-1:0];
      ly_q[0]  <= py_q[QW-1:0];
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      dd_q[0]  <= d_c_q;
      sd_q[0]  <= side_c_q;
    end
  end

  // one quotient bit per stage for each lane
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [AW:0] tx, ty, fx, fy;
    logic        gex, gey;

    assign tx  = {rx_q[k], lx_q[k][QW-1]};
    assign ty  = {ry_q[k], ly_q[k][QW-1]};
    assign gex = tx >= {1'b0, dd_q[k]};
    assign gey = ty >= {1'b0, dd_q[k]};
    assign fx  = tx - {1'b0, dd_q[k]};
    assign fy  = ty - {1'b0, dd_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k+1]  <= gex ? fx[AW-1:0] : tx[AW-1:0];
        ry_q[k+1]  <= gey ? fy[AW-1:0] : ty[AW-1:0];
        lx_q[k+1]  <= {lx_q[k][QW-2:0], 1'b0};
        ly_q[k+1]  <= {ly_q[k][QW-2:0], 1'b0};
        qx_q[k+1]  <= {qx_q[k][QW-2:0], gex};
        qy_q[k+1]  <= {qy_q[k][QW-2:0], gey};
        dd_q[k+1]  <= dd_q[k];
        ovx_q[k+1] <= ovx_q[k];
        ovy_q[k+1] <= ovy_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  // stage e: sign, saturation and zero depth
  function automatic logic [QW-1:0] sat_quo(input logic [QW-1:0] q, input logic ov,
                                            input logic neg);
    logic [QW-1:0] r;
    if (neg) begin
      if (ov || (q[QW-1] && (q[QW-2:0] != '0))) begin
        r = {1'b1, {(QW-1){1'b0}}};
      end else begin
        r = ~q + 1'b1;
      end
    end else begin
      if (ov || q[QW-1]) begin
        r = {1'b0, {(QW-1){1'b1}}};
      end else begin
        r = q;
      end
    end
    return r;
  endfunction

  ppp_out_t res_d;

  always_comb begin
    if (sd_q[NDIV].zero) begin
      res_d = '0;
      res_d.depth_zero = 1'b1;
    end else begin
      res_d.screen_x   = sat_quo(qx_q[NDIV], ovx_q[NDIV], sd_q[NDIV].neg_x);
      res_d.screen_y   = sat_quo(qy_q[NDIV], ovy_q[NDIV], sd_q[NDIV].neg_y);
      res_d.view_depth = sd_q[NDIV].depth;
      res_d.depth_zero = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_o <= res_d;
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NST-1];

endmodule

[design/perspective_point_projection.sv]
// top level of the perspective point projection block
// depends on ppp_pkg, ppp_rotate and ppp_project
`timescale 1ns / 1ps

// Projects one 3D point per clock while stall_o is low: yaw rotation, pitch
// rotation, offset add, then x and y scaled by the focal distance and divided
// by depth. An accepted word passes the input register, both rotations, the
// offset add, the projection pipeline and the output register. The latency
// is set mostly by the 32 step restoring divider, one quotient bit per stage,
// run as two lanes side by side. Two output registers (output plus skid) let
// the input keep taking words while a result waits; stall_o rises only when
// both are full. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, with trig values in signed fixed point with
// TRIG_FRAC_BITS fraction bits and coordinates with COORD_FRAC_BITS.

module perspective_point_projection
  import ppp_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  ppp_in_t             in_word_i,
  output logic                valid_o,
  input  logic                stall_i,
  output ppp_out_t            out_word_o
);

  localparam int unsigned R1W = CoordW + TrigW + 1 - TRIG_FRAC_BITS;
  localparam int unsigned PIW = (R1W > CoordW) ? R1W : CoordW;
  localparam int unsigned R2W = PIW + TrigW + 1 - TRIG_FRAC_BITS;
  localparam int unsigned MW1 = (R1W > R2W) ? R1W : R2W;
  localparam int unsigned MW = (MW1 > CoordW) ? MW1 : CoordW;
  localparam int unsigned VW = MW + 1;

  // configuration registers
  logic signed [TrigW-1:0]  cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic signed [CoordW-1:0] offset_x_q, offset_y_q, offset_z_q;
  logic [FocalW-1:0]        focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q   <= TrigW'(1 << TRIG_FRAC_BITS);
      sin_yaw_q   <= '0;
      cos_pitch_q <= TrigW'(1 << TRIG_FRAC_BITS);
      sin_pitch_q <= '0;
      offset_x_q  <= '0;
      offset_y_q  <= '0;
      offset_z_q  <= '0;
      focal_q     <= FocalW'(1 << COORD_FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COS_YAW:        cos_yaw_q   <= cfg_wdata_i[TrigW-1:0];
        REG_SIN_YAW:        sin_yaw_q   <= cfg_wdata_i[TrigW-1:0];
        REG_COS_PITCH:      cos_pitch_q <= cfg_wdata_i[TrigW-1:0];
        REG_SIN_PITCH:      sin_pitch_q <= cfg_wdata_i[TrigW-1:0];
        REG_OFFSET_X:       offset_x_q  <= cfg_wdata_i[CoordW-1:0];
        REG_OFFSET_Y:       offset_y_q  <= cfg_wdata_i[CoordW-1:0];
        REG_OFFSET_Z:       offset_z_q  <= cfg_wdata_i[CoordW-1:0];
        REG_FOCAL_DISTANCE: focal_q     <= cfg_wdata_i[FocalW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid register is full
  logic en;
  logic skid_v_q, out_v_q;

  assign en = !skid_v_q;
  assign stall_o = skid_v_q;

  // valid bits for the front stages
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // input register
  logic signed [CoordW-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= in_word_i.point_x;
      y_q <= in_word_i.point_y;
      z_q <= in_word_i.point_z;
    end
  end

  // rotation about y
  logic signed [R1W-1:0] x1, z1;
  logic signed [CoordW-1:0] y_d1_q, y_d2_q;

  ppp_rotate #(
    .IN_W          (CoordW),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_yaw (
    .clk_i,
    .en_i (en),
    .a_i  (x_q),
    .b_i  (z_q),
    .cos_i(cos_yaw_q),
    .sin_i(sin_yaw_q),
    .a_o  (x1),
    .b_o  (z1)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_d1_q <= y_q;
      y_d2_q <= y_d1_q;
    end
  end

  // rotation about x
  logic signed [R2W-1:0] y2, z2;
  logic signed [R1W-1:0] x1_d1_q, x1_d2_q;
  logic signed [PIW-1:0] y_ext, z1_ext;

  assign y_ext  = PIW'(y_d2_q);
  assign z1_ext = PIW'(z1);

  ppp_rotate #(
    .IN_W          (PIW),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_pitch (
    .clk_i,
    .en_i (en),
    .a_i  (y_ext),
    .b_i  (z1_ext),
    .cos_i(cos_pitch_q),
    .sin_i(sin_pitch_q),
    .a_o  (y2),
    .b_o  (z2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_d1_q <= x1;
      x1_d2_q <= x1_d1_q;
    end
  end

  // offset add, kept wide
  logic signed [VW-1:0] xv_q, yv_q, zv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xv_q <= VW'(x1_d2_q) + VW'(offset_x_q);
      yv_q <= VW'(y2) + VW'(offset_y_q);
      zv_q <= VW'(z2) + VW'(offset_z_q);
    end
  end

  // projection and divide
  logic     proj_v;
  ppp_out_t proj_res;

  ppp_project #(
    .VW(VW)
  ) u_project (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (vld_q[5]),
    .xv_i    (xv_q),
    .yv_i    (yv_q),
    .zv_i    (zv_q),
    .focal_i (focal_q),
    .valid_o (proj_v),
    .result_o(proj_res)
  );

  // output register with skid
  ppp_out_t out_q, skid_q;
  logic     push, pop;

  assign push = en && proj_v;
  assign pop  = out_v_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else begin
      out_v_q  <= push || (out_v_q && !pop);
      skid_v_q <= push && out_v_q && !pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_q <= proj_res;
      end else begin
        skid_q <= proj_res;
      end
    end
  end

  assign valid_o    = out_v_q;
  assign out_word_o = out_q;

endmodule

[design/ppp_check.sv]
// port level checks for the perspective point projection block
// depends on ppp_pkg; bound to perspective_point_projection
`timescale 1ns / 1ps

module ppp_check
  import ppp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     valid_i,
  input logic     stall_o,
  input ppp_in_t  in_word_i,
  input logic     valid_o,
  input logic     stall_i,
  input ppp_out_t out_word_o
);

  // zero depth forces all numeric outputs to zero
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_word_o.depth_zero |->
      out_word_o.screen_x == '0 && out_word_o.screen_y == '0 &&
      out_word_o.view_depth == '0)
    else $error("zero depth word with nonzero outputs");

  // a word not flagged as zero depth carries a nonzero depth
  a_depth_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_word_o.depth_zero |-> out_word_o.view_depth != '0)
    else $error("depth zero flag low with zero depth");

  // input stalls only after the output was held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> $past(valid_o && stall_i))
    else $error("input stalled without output back pressure");

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // a stalled input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

endmodule

bind perspective_point_projection ppp_check u_ppp_check (.*);

[sim/ppp_checker.sv]
// checker for the perspective point projection block: watches both word
// channels and the register port, predicts each result and compares it
// depends on ppp_pkg
`timescale 1ns / 1ps

module ppp_checker
  import ppp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                valid_i,
  input  logic                stall_o,
  input  ppp_in_t             in_word_i,
  input  logic                valid_o,
  input  logic                stall_i,
  input  ppp_out_t            out_word_o,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int TrigFrac = 14;

  // shadow copy of the register file
  logic signed [TrigW-1:0]  cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic signed [CoordW-1:0] off_x_q, off_y_q, off_z_q;
  logic [FocalW-1:0]        focal_q;

  ppp_out_t expected_words[$];

  assign pending_o = expected_words.size();

  function automatic longint round_trig(longint v);
    return (v + (longint'(1) << (TrigFrac - 1))) >>> TrigFrac;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact scaled quotient, truncated toward zero
  function automatic logic signed [31:0] scale_div(longint num, longint den);
    logic signed [127:0] n, d, f;
    n = num;
    d = den;
    f = {97'd0, focal_q};
    return clamp32((n * f) / d);
  endfunction

  function automatic ppp_out_t project_point(ppp_in_t p);
    longint x, y, z, cy, sy, cp, sp, x1, z1, y2, z2, xv, yv, zv;
    ppp_out_t r;
    x = p.point_x; y = p.point_y; z = p.point_z;
    cy = cos_yaw_q; sy = sin_yaw_q; cp = cos_pitch_q; sp = sin_pitch_q;
    x1 = round_trig(cy * x + sy * z);
    z1 = round_trig(-sy * x + cy * z);
    y2 = round_trig(cp * y + sp * z1);
    z2 = round_trig(-sp * y + cp * z1);
    xv = x1 + longint'(off_x_q);
    yv = y2 + longint'(off_y_q);
    zv = z2 + longint'(off_z_q);
    r = '0;
    if (zv == 0) begin
      r.depth_zero = 1'b1;
    end else begin
      r.screen_x = scale_div(xv, zv);
      r.screen_y = scale_div(yv, zv);
      r.view_depth = clamp32(zv);
    end
    return r;
  endfunction

  // register shadow, input prediction, output comparison
  always @(posedge clk_i or negedge rst_ni) begin
    ppp_out_t exp_w;
    if (!rst_ni) begin
      cos_yaw_q <= 16'sd16384;
      sin_yaw_q <= '0;
      cos_pitch_q <= 16'sd16384;
      sin_pitch_q <= '0;
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
      focal_q <= 31'd65536;
      expected_words.delete();
      errors_o <= 0;
    end else begin
      if (valid_i && !stall_o) expected_words = {expected_words, project_point(in_word_i)};
      if (valid_o && !stall_i) begin
        if (expected_words.size() == 0) begin
          if (errors_o < 10) $display("unexpected output word %h", out_word_o);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_word_o) begin
            if (errors_o < 10)
              $display("mismatch: exp x=%0d y=%0d d=%0d z=%b got x=%0d y=%0d d=%0d z=%b",
                       exp_w.screen_x, exp_w.screen_y, exp_w.view_depth, exp_w.depth_zero,
                       out_word_o.screen_x, out_word_o.screen_y, out_word_o.view_depth,
                       out_word_o.depth_zero);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COS_YAW:        cos_yaw_q <= cfg_wdata_i[TrigW-1:0];
          REG_SIN_YAW:        sin_yaw_q <= cfg_wdata_i[TrigW-1:0];
          REG_COS_PITCH:      cos_pitch_q <= cfg_wdata_i[TrigW-1:0];
          REG_SIN_PITCH:      sin_pitch_q <= cfg_wdata_i[TrigW-1:0];
          REG_OFFSET_X:       off_x_q <= cfg_wdata_i;
          REG_OFFSET_Y:       off_y_q <= cfg_wdata_i;
          REG_OFFSET_Z:       off_z_q <= cfg_wdata_i;
          REG_FOCAL_DISTANCE: focal_q <= cfg_wdata_i[FocalW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[sim/tb.sv]
// testbench top for the perspective point projection block: clock, reset,
// register setups, point stimulus with bursts and stalls, and the verdict
// depends on ppp_pkg, perspective_point_projection and ppp_checker
`timescale 1ns / 1ps

module tb;
  import ppp_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                valid_i = 1'b0;
  logic                stall_o;
  ppp_in_t             in_word_i = '0;
  logic                valid_o;
  logic                stall_i = 1'b0;
  ppp_out_t            out_word_o;
  int                  pending, errors;
  int                  cycles = 0;
  logic                hold_req = 1'b0;
  logic                hold_done = 1'b0;
  int                  stall_mode = 0;

  perspective_point_projection i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .valid_i, .stall_o, .in_word_i, .valid_o, .stall_i, .out_word_o
  );

  ppp_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .valid_i, .stall_o, .in_word_i, .valid_o, .stall_i, .out_word_o,
    .pending_o(pending), .errors_o(errors)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk_i) begin
    int hold_cnt;
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_i <= 1'b1;
      for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(negedge clk_i);
      stall_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 3) == 0);
        2: stall_i <= ($urandom_range(0, 1) == 0);
        default: stall_i <= ($urandom_range(0, 7) != 0);
      endcase
      if ($urandom_range(0, 40) == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  // offer one word and keep it until taken; leaves valid high
  task automatic send_word(ppp_in_t w);
    valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block must be empty before registers change
  task automatic wait_empty();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      5: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    case ($urandom_range(0, 5))
      0: return 32'({$urandom_range(0, 65535), 16'sd16384});
      1: return 32'({$urandom_range(0, 65535), -16'sd16384});
      2: return $urandom;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  function automatic ppp_in_t pick_point();
    ppp_in_t p;
    p.point_x = pick_coord();
    p.point_y = pick_coord();
    p.point_z = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_coord();
    return p;
  endfunction

  task automatic random_points(int n);
    int i, burst;
    i = 0;
    while (i < n) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && i < n) begin
        send_word(pick_point());
        burst--;
        i++;
      end
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  task automatic random_setup();
    write_reg(REG_COS_YAW, pick_trig());
    write_reg(REG_SIN_YAW, pick_trig());
    write_reg(REG_COS_PITCH, pick_trig());
    write_reg(REG_SIN_PITCH, pick_trig());
    write_reg(REG_OFFSET_X, ($urandom_range(0, 1)) ? $urandom : pick_coord());
    write_reg(REG_OFFSET_Y, ($urandom_range(0, 1)) ? $urandom : pick_coord());
    write_reg(REG_OFFSET_Z, ($urandom_range(0, 2) == 0) ? 32'd0 : pick_coord());
    case ($urandom_range(0, 3))
      0: write_reg(REG_FOCAL_DISTANCE, 32'd1);
      1: write_reg(REG_FOCAL_DISTANCE, 32'hffffffff);
      default: write_reg(REG_FOCAL_DISTANCE, $urandom);
    endcase
  endtask

  initial begin
    ppp_in_t p;
    int ph;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed points on reset setup: zero depth, extremes, tiny depth
    p = '0;                                     send_word(p);
    p = '{32'h7fffffff, 32'h80000000, 32'd1};   send_word(p);
    p = '{32'h80000000, 32'h7fffffff, 32'hffffffff}; send_word(p);
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}; send_word(p);
    p = '{32'h80000000, 32'h80000000, 32'h80000000}; send_word(p);
    p = '{32'h00010000, 32'hffff0000, 32'd0};   send_word(p);
    p = '{32'h00030000, 32'h00050000, 32'h00020000}; send_word(p);
    p = '{32'hfffd0000, 32'h00050000, 32'hfffe0000}; send_word(p);
    wait_empty();

    // quarter turns, zero focal low bits, overflow in the trig path
    write_reg(REG_COS_YAW, 32'd0);
    write_reg(REG_SIN_YAW, 32'hffff4000);
    write_reg(REG_COS_PITCH, 32'h0000c000);
    write_reg(REG_SIN_PITCH, 32'h00008000);
    write_reg(REG_OFFSET_X, 32'h7fffffff);
    write_reg(REG_OFFSET_Y, 32'h80000000);
    write_reg(REG_OFFSET_Z, 32'h00010000);
    write_reg(REG_FOCAL_DISTANCE, 32'h80000000);
    p = '0;                                     send_word(p);
    p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff}; send_word(p);
    p = '{32'h80000000, 32'h7fffffff, 32'h80000000}; send_word(p);
    p = '{32'h00000001, 32'hffffffff, 32'h00000001}; send_word(p);
    random_points(10);
    wait_empty();

    // receiver holds off while words keep coming, block fills up
    hold_req <= 1'b1;
    random_points(120);
    wait_empty();

    for (ph = 0; ph < 8; ph++) begin
      wait_empty();
      random_setup();
      random_points(100);
    end
    random_points(10);
    wait_empty();
    write_reg(REG_COS_YAW, 32'd0);
    write_reg(REG_FOCAL_DISTANCE, 32'h7fffffff);
    write_reg(REG_COS_YAW, 32'd16384);
    random_points(40);

    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
